// ===== src/bba_pkg.sv =====
// Shared types and constants for the block bitmap allocator.
// Holds request kinds, status codes, register indexes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 65536;
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned ADDR_LIMIT     = 65536;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned BN_W   = 16;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FORMAT = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  localparam logic [CNT_W-1:0] TOTAL_RST    = 17'd65536;
  localparam logic [CNT_W-1:0] RESERVED_RST = 17'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic set_range;
    logic set_nofree;
    logic div1;
    logic div2;
    logic rd;
    logic modify;
    logic scan_start;
    logic scan;
    logic fmt_start;
    logic fmt_step;
    logic fmt_finish;
    logic load_out;
  } bba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic range_bad;
    logic count_zero;
    logic scan_done;
    logic sweep_last;
    logic out_free;
  } bba_sts_t;

endpackage

`default_nettype wire

// ===== src/bba_req_if.sv =====
// Request channel: valid/ready handshake carrying one allocator request.
// Depends on bba_pkg for field widths.
`default_nettype none

interface bba_req_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::KIND_W-1:0]    kind;
  logic [bba_pkg::BN_W-1:0]      block_number;
  logic                          bit_in;

  modport source (output valid, kind, block_number, bit_in, input ready);
  modport sink   (input valid, kind, block_number, bit_in, output ready);
endinterface

`default_nettype wire

// ===== src/bba_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one allocator result.
// Depends on bba_pkg for field widths.
`default_nettype none

interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::ST_W-1:0]      status;
  logic [bba_pkg::BN_W-1:0]      result_block;
  logic                          bit_out;
  logic [bba_pkg::CNT_W-1:0]     free_count;

  modport source (output valid, status, result_block, bit_out, free_count, input ready);
  modport sink   (input valid, status, result_block, bit_out, free_count, output ready);
endinterface

`default_nettype wire

// ===== src/bba_regs.sv =====
// APB-style configuration registers: total and reserved block counts.
// Depends on bba_pkg.
`default_nettype none

module bba_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]    pwdata,
  output logic      [bba_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic      [bba_pkg::CNT_W-1:0]     total_o,
  output logic      [bba_pkg::CNT_W-1:0]     reserved_o
);

  logic [bba_pkg::CNT_W-1:0] total_q, reserved_q;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  // Byte lanes are ignored: bit 2 picks the register
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= bba_pkg::TOTAL_RST;
      reserved_q <= bba_pkg::RESERVED_RST;
    end else if (wr_en) begin
      if (reg_sel == bba_pkg::REG_TOTAL) begin
        total_q <= pwdata[bba_pkg::CNT_W-1:0];
      end else begin
        reserved_q <= pwdata[bba_pkg::CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == bba_pkg::REG_TOTAL) begin
      prdata = {{(bba_pkg::DATA_W-bba_pkg::CNT_W){1'b0}}, total_q};
    end else begin
      prdata = {{(bba_pkg::DATA_W-bba_pkg::CNT_W){1'b0}}, reserved_q};
    end
  end

  assign total_o    = total_q;
  assign reserved_o = reserved_q;

endmodule

`default_nettype wire

// ===== src/bba_ctrl.sv =====
// Controller state machine for the allocator: sequences the datapath per request kind.
// Depends on bba_pkg for kinds and the command/status structs.
`default_nettype none

module bba_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  input  wire logic [bba_pkg::KIND_W-1:0]  req_kind_i,
  output logic                             req_ready_o,
  input  wire bba_pkg::bba_sts_t           sts_i,
  output bba_pkg::bba_cmd_t                cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV1  = 9'b000000100,
    S_DIV2  = 9'b000001000,
    S_RD    = 9'b000010000,
    S_MOD   = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_FMT   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.fmt_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          case (req_kind_i)
            bba_pkg::KIND_ALLOC: begin
              if (sts_i.count_zero) begin
                cmd_o.set_nofree = 1'b1;
                state_d = S_DONE;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d = S_SCAN;
              end
            end
            bba_pkg::KIND_FREE, bba_pkg::KIND_READ, bba_pkg::KIND_WRITE: begin
              if (sts_i.range_bad) begin
                cmd_o.set_range = 1'b1;
                state_d = S_DONE;
              end else begin
                state_d = S_DIV1;
              end
            end
            bba_pkg::KIND_FORMAT: begin
              cmd_o.fmt_start = 1'b1;
              state_d = S_FMT;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIV1: begin
        cmd_o.div1 = 1'b1;
        state_d = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div2 = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        cmd_o.modify = 1'b1;
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_FMT: begin
        cmd_o.fmt_step = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.fmt_finish = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/bba_dp.sv =====
// Allocator datapath: occupancy map memory, free count, scan and sweep counters,
// block-number split, result and output registers. Depends on bba_pkg.
`default_nettype none

module bba_dp #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bba_pkg::bba_cmd_t             cmd_i,
  output bba_pkg::bba_sts_t                  sts_o,
  input  wire logic [bba_pkg::CNT_W-1:0]     cfg_total_i,
  input  wire logic [bba_pkg::CNT_W-1:0]     cfg_reserved_i,
  input  wire logic [bba_pkg::KIND_W-1:0]    req_kind_i,
  input  wire logic [bba_pkg::BN_W-1:0]      req_block_number_i,
  input  wire logic                          req_bit_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [bba_pkg::ST_W-1:0]      out_status_o,
  output logic      [bba_pkg::BN_W-1:0]      out_result_block_o,
  output logic                               out_bit_out_o,
  output logic      [bba_pkg::CNT_W-1:0]     out_free_count_o
);

  localparam int unsigned CW        = bba_pkg::CNT_W;
  localparam int unsigned NW        = bba_pkg::BN_W;
  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned OW        = $clog2(WORD_BITS);
  localparam int unsigned BW        = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int unsigned XW        = (BW > CW) ? BW : CW;
  localparam logic [CW-1:0] LIMIT   = CW'((MAX_BLOCKS < bba_pkg::ADDR_LIMIT) ?
                                          MAX_BLOCKS : bba_pkg::ADDR_LIMIT);
  localparam logic [WORD_BITS-1:0] FULL = '1;
  // Ceiling reciprocal: exact quotient for every 16-bit numerator
  localparam int unsigned DIV_SH    = 23;
  localparam int unsigned RW        = 21;
  localparam logic [RW-1:0] RECIP   = RW'(((64'd1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);
  localparam int unsigned PW        = NW + RW;
  localparam int unsigned MW        = NW + 6;

  function automatic logic [OW-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [OW-1:0] k;
    k = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) k = OW'(i);
    end
    return k;
  endfunction

  // Effective limits
  logic [CW-1:0] total_eff, rsv_eff;
  assign total_eff = (cfg_total_i > LIMIT) ? LIMIT : cfg_total_i;
  assign rsv_eff   = (cfg_reserved_i < total_eff) ? cfg_reserved_i : total_eff;

  // Map memory
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // Request capture
  logic [bba_pkg::KIND_W-1:0] kind_q;
  logic [NW-1:0]              bn_q;
  logic                       bit_in_q;
  logic [NW-1:0]              quo_q;
  logic [AW-1:0]              word_q;
  logic [OW-1:0]              bit_q;
  logic [PW-1:0]              prod;
  logic [MW-1:0]              qmul;

  assign prod = PW'(bn_q) * PW'(RECIP);
  assign qmul = MW'(quo_q) * MW'(WORD_BITS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q   <= req_kind_i;
      bn_q     <= req_block_number_i;
      bit_in_q <= req_bit_in_i;
    end
    if (cmd_i.div1) quo_q <= prod[DIV_SH +: NW];
    if (cmd_i.div2) begin
      word_q <= AW'(quo_q);
      bit_q  <= OW'(bn_q - qmul[NW-1:0]);
    end
  end

  // Scan counters
  logic          scan_pend_q;
  logic [AW-1:0] iss_w_q, pend_w_q;
  logic [XW-1:0] iss_base_q, pend_base_q;
  logic          iss_more, scan_hit, scan_issue;
  logic [OW-1:0] zero_k;
  logic [XW-1:0] found;
  logic          found_ok;

  assign iss_more   = iss_base_q < XW'(total_eff);
  assign scan_hit   = scan_pend_q && (rdata_q != FULL);
  assign scan_issue = cmd_i.scan && iss_more && !scan_hit;
  assign zero_k     = first_zero(rdata_q);
  assign found      = pend_base_q + XW'(zero_k);
  assign found_ok   = found < XW'(total_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_pend_q <= 1'b0;
      iss_w_q     <= '0;
      iss_base_q  <= '0;
      pend_w_q    <= '0;
      pend_base_q <= '0;
    end else if (cmd_i.scan_start) begin
      scan_pend_q <= 1'b0;
      iss_w_q     <= '0;
      iss_base_q  <= '0;
    end else if (cmd_i.scan) begin
      scan_pend_q <= scan_issue;
      if (scan_issue) begin
        pend_w_q    <= iss_w_q;
        pend_base_q <= iss_base_q;
        iss_w_q     <= iss_w_q + AW'(1);
        iss_base_q  <= iss_base_q + XW'(WORD_BITS);
      end
    end
  end

  // Format / clear sweep; reset leaves the reserved bound at zero for the clearing pass
  logic [AW-1:0]        fmt_w_q;
  logic [XW-1:0]        fmt_base_q, fmt_rsv_q, fmt_diff;
  logic [WORD_BITS-1:0] fmt_pat;
  logic                 sweep_last;

  assign sweep_last = fmt_w_q == AW'(MAP_WORDS - 1);
  assign fmt_diff   = fmt_rsv_q - fmt_base_q;

  always_comb begin
    fmt_pat = '0;
    if (fmt_rsv_q > fmt_base_q) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        fmt_pat[j] = XW'(j) < fmt_diff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_w_q    <= '0;
      fmt_base_q <= '0;
      fmt_rsv_q  <= '0;
    end else if (cmd_i.fmt_start) begin
      fmt_w_q    <= '0;
      fmt_base_q <= '0;
      fmt_rsv_q  <= XW'(rsv_eff);
    end else if (cmd_i.fmt_step) begin
      fmt_w_q    <= sweep_last ? '0 : fmt_w_q + AW'(1);
      fmt_base_q <= fmt_base_q + XW'(WORD_BITS);
    end
  end

  // Memory port selection
  logic [WORD_BITS-1:0] bit_mask, zero_mask;
  assign bit_mask  = WORD_BITS'(1) << bit_q;
  assign zero_mask = WORD_BITS'(1) << zero_k;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_q;
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = word_q;
    if (cmd_i.fmt_step) begin
      mem_we    = 1'b1;
      mem_waddr = fmt_w_q;
      mem_wdata = fmt_pat;
    end else if (cmd_i.scan) begin
      mem_re    = scan_issue;
      mem_raddr = iss_w_q;
      mem_we    = scan_hit && found_ok;
      mem_waddr = pend_w_q;
      mem_wdata = rdata_q | zero_mask;
    end else if (cmd_i.rd) begin
      mem_re = 1'b1;
    end else if (cmd_i.modify) begin
      case (kind_q)
        bba_pkg::KIND_FREE: begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q & ~bit_mask;
        end
        bba_pkg::KIND_WRITE: begin
          mem_we    = 1'b1;
          mem_wdata = bit_in_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Free count and result registers
  logic [CW-1:0]               cnt_q;
  logic [bba_pkg::ST_W-1:0]    res_status_q;
  logic [NW-1:0]               res_block_q;
  logic                        res_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.fmt_finish) begin
      cnt_q <= total_eff - fmt_rsv_q[CW-1:0];
    end else if (cmd_i.scan && scan_hit && found_ok) begin
      cnt_q <= cnt_q - CW'(1);
    end else if (cmd_i.modify && kind_q == bba_pkg::KIND_FREE && cnt_q < total_eff) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_status_q <= cmd_i.set_range  ? bba_pkg::ST_RANGE :
                      cmd_i.set_nofree ? bba_pkg::ST_NOFREE : bba_pkg::ST_OK;
      res_block_q  <= '0;
      res_bit_q    <= 1'b0;
    end else if (cmd_i.scan && scan_hit) begin
      if (found_ok) begin
        res_block_q <= found[NW-1:0];
      end else begin
        res_status_q <= bba_pkg::ST_NOFREE;
      end
    end else if (cmd_i.scan && !scan_pend_q && !iss_more) begin
      res_status_q <= bba_pkg::ST_NOFREE;
    end else if (cmd_i.modify) begin
      if (kind_q == bba_pkg::KIND_FREE) res_block_q <= bn_q;
      if (kind_q == bba_pkg::KIND_READ) res_bit_q <= rdata_q[bit_q];
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_o       <= res_status_q;
      out_result_block_o <= res_block_q;
      out_bit_out_o      <= res_bit_q;
      out_free_count_o   <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.range_bad  = {1'b0, req_block_number_i} >= total_eff;
  assign sts_o.count_zero = cnt_q == '0;
  assign sts_o.scan_done  = scan_hit || (!scan_pend_q && !iss_more);
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== src/block_bitmap_allocator_unit.sv =====
// Top level of the first-fit block bitmap allocator.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_regs, bba_ctrl and bba_dp.
//
//   channel   direction  handshake             payload
//   req_i     in         valid/ready           kind, block_number, bit_in
//   rsp_o     out        valid/ready           status, result_block, bit_out, free_count
//   apb       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// One request at a time. Allocate scans at most ceil(total/WORD_BITS) map words through the
// single map read port, one word per cycle; format writes all MAP_WORDS words, one
// word written per cycle; free, read bit and write bit in range pass the DIV1, DIV2, RD and MOD states.
// After reset a clearing pass over all MAP_WORDS words zeroes the map before a request is taken.
// A new request is taken while a result waits in the output register; a finished request
// holds until that register frees up.
`default_nettype none

module block_bitmap_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  bba_req_if.sink                            req_i,
  bba_rsp_if.source                          rsp_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]    pwdata,
  output logic      [bba_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic [bba_pkg::CNT_W-1:0] cfg_total, cfg_reserved;
  bba_pkg::bba_cmd_t         cmd;
  bba_pkg::bba_sts_t         sts;

  bba_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .total_o    (cfg_total),
    .reserved_o (cfg_reserved)
  );

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_total_i        (cfg_total),
    .cfg_reserved_i     (cfg_reserved),
    .req_kind_i         (req_i.kind),
    .req_block_number_i (req_i.block_number),
    .req_bit_in_i       (req_i.bit_in),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .out_status_o       (rsp_o.status),
    .out_result_block_o (rsp_o.result_block),
    .out_bit_out_o      (rsp_o.bit_out),
    .out_free_count_o   (rsp_o.free_count)
  );

endmodule

`default_nettype wire

// ===== tb/sv/bba_check_pkg.sv =====
// Shadow copy of the block bitmap allocator for the testbench: occupancy map, free
// count and register values, plus the queue of replies the block still owes.
// Depends on bba_pkg for field widths, request kinds and status codes.
package bba_check_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int unsigned MAP_BITS   = MAX_BLOCKS_DEF;
  localparam int unsigned PRINT_CAP  = 40;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [BN_W-1:0]  block_no;
    logic             bit_out;
    logic [CNT_W-1:0] free_count;
  } reply_t;

  class bitmap_shadow;
    bit               used_map [MAP_BITS];
    logic [CNT_W-1:0] free_blocks;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] reserved_reg;
    reply_t           awaited [$];
    int unsigned      failures;
    int unsigned      requests_seen;
    int unsigned      replies_seen;
    int unsigned      formats_seen;

    function new();
      free_blocks   = '0;
      total_reg     = TOTAL_RST;
      reserved_reg  = RESERVED_RST;
      failures      = 0;
      requests_seen = 0;
      replies_seen  = 0;
      formats_seen  = 0;
    endfunction

    // Blocks actually managed: the register clamped to the map size and address range.
    function int unsigned span();
      int unsigned t;
      t = total_reg;
      if (t > MAX_BLOCKS_DEF) t = MAX_BLOCKS_DEF;
      if (t > ADDR_LIMIT) t = ADDR_LIMIT;
      return t;
    endfunction

    function void take_request(input logic [KIND_W-1:0] kind, input logic [BN_W-1:0] bn,
                               input logic bit_in);
      reply_t      r;
      int unsigned limit;
      int unsigned rsv;
      int unsigned idx;
      limit = span();
      r = '0;
      requests_seen++;
      case (kind)
        KIND_ALLOC: begin
          if (free_blocks == 0) begin
            r.status = ST_NOFREE;
          end else begin
            idx = 0;
            while (idx < limit && used_map[idx]) idx++;
            // the count can say free while every managed bit is set
            if (idx >= limit) begin
              r.status = ST_NOFREE;
            end else begin
              used_map[idx] = 1'b1;
              free_blocks = free_blocks - 1'b1;
              r.block_no = BN_W'(idx);
            end
          end
        end
        KIND_FREE, KIND_READ, KIND_WRITE: begin
          if (bn >= limit) begin
            r.status = ST_RANGE;
          end else if (kind == KIND_FREE) begin
            used_map[bn] = 1'b0;
            // saturate: a double free never pushes the count past the total
            if (free_blocks < limit) free_blocks = free_blocks + 1'b1;
            r.block_no = bn;
          end else if (kind == KIND_READ) begin
            r.bit_out = used_map[bn];
          end else begin
            used_map[bn] = bit_in;
          end
        end
        KIND_FORMAT: begin
          rsv = (reserved_reg < limit) ? reserved_reg : limit;
          foreach (used_map[i]) used_map[i] = (i < rsv);
          free_blocks = CNT_W'(limit - rsv);
          formats_seen++;
        end
        default: begin
        end
      endcase
      r.free_count = free_blocks;
      awaited.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= PRINT_CAP)
          $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void match_reply(input reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= PRINT_CAP)
          $display("%0t: reply with nothing pending, expected none got status %0d block %0d",
                   $time, got.status, got.block_no);
        return;
      end
      want = awaited.pop_front();
      replies_seen++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("result_block", 32'(want.block_no), 32'(got.block_no));
      compare_field("bit_out", 32'(want.bit_out), 32'(got.bit_out));
      compare_field("free_count", 32'(want.free_count), 32'(got.free_count));
    endfunction
  endclass

endpackage

// ===== tb/sv/block_bitmap_allocator_unit_test.sv =====
// Testbench top for block_bitmap_allocator_unit: directed and random requests with
// random stalls on both channels, register changes over APB between phases.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_check_pkg and block_bitmap_allocator_unit.
module block_bitmap_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;
  import bba_check_pkg::*;

  localparam logic [PADDR_W-1:0] TOTAL_ADDR    = {REG_TOTAL, 2'b00};
  localparam logic [PADDR_W-1:0] RESERVED_ADDR = {REG_RESERVED, 2'b00};

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam int unsigned IDLE_PCT     = 28;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 26;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_shadow shadow;
  bit           steady;
  bit           hold_wanted;

  block_bitmap_allocator_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // Entered on a falling edge; returns on the falling edge after the transaction.
  task automatic offer(input logic [KIND_W-1:0] kind, input logic [BN_W-1:0] bn,
                       input logic bit_in);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid        <= 1'b0;
      req_ch.kind         <= KIND_W'($urandom);
      req_ch.block_number <= BN_W'($urandom);
      req_ch.bit_in       <= 1'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.block_number <= bn;
    req_ch.bit_in       <= bit_in;
    do @(posedge clk_i); while (!req_ch.ready);
    shadow.take_request(kind, bn, bit_in);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every owed reply is back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (shadow.awaited.size() != 0) @(negedge clk_i);
  endtask

  // Write a register, then read it back.
  task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] stored;
    stored = DATA_W'(value[CNT_W-1:0]);
    for (int pass = 0; pass < 2; pass++) begin
      @(negedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (pass == 0);
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (pass == 0) begin
        if (addr == TOTAL_ADDR) shadow.total_reg = value[CNT_W-1:0];
        else shadow.reserved_reg = value[CNT_W-1:0];
      end else if (prdata !== stored) begin
        shadow.failures++;
        $display("%0t: register %0d read expected %0d got %0d", $time, addr, stored, prdata);
      end
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic configure(input int unsigned total, input int unsigned reserved);
    program_reg(TOTAL_ADDR, {(DATA_W-CNT_W)'($urandom), CNT_W'(total)});
    program_reg(RESERVED_ADDR, {(DATA_W-CNT_W)'($urandom), CNT_W'(reserved)});
  endtask

  // Format first so the map is in a known shape, then a random mix of requests.
  task automatic random_phase(input int unsigned items);
    int unsigned       limit;
    int unsigned       pick;
    logic [KIND_W-1:0] kind;
    logic [BN_W-1:0]   bn;
    limit = shadow.span();
    offer(KIND_FORMAT, BN_W'($urandom), 1'($urandom));
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) kind = KIND_ALLOC;
      else if (pick < 62) kind = KIND_FREE;
      else if (pick < 76) kind = KIND_READ;
      else if (pick < 90) kind = KIND_WRITE;
      else if (pick < 94) kind = KIND_FORMAT;
      else kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      if ($urandom_range(0, 99) < 80) bn = BN_W'($urandom_range(0, limit - 1));
      else bn = BN_W'($urandom);
      offer(kind, bn, 1'($urandom));
    end
  endtask

  initial begin : reply_pacer
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      shadow.match_reply({rsp_ch.status, rsp_ch.result_block, rsp_ch.bit_out,
                          rsp_ch.free_count});
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned reserved;
    int unsigned pick;
    shadow = new();
    steady = 1'b0;
    hold_wanted = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_ALLOC;
    req_ch.block_number = '0;
    req_ch.bit_in = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at their reset values; the count is empty until the first format.
    offer(KIND_ALLOC, 16'hFFFF, 1'b1);
    offer(KIND_READ, 16'hFFFF, 1'b0);
    offer(KIND_FORMAT, 16'h0000, 1'b0);
    offer(KIND_ALLOC, 16'h0000, 1'b0);
    offer(KIND_ALLOC, 16'h0000, 1'b0);
    offer(KIND_FREE, 16'h0001, 1'b0);
    offer(KIND_WRITE, 16'hFFFF, 1'b1);
    offer(KIND_READ, 16'hFFFF, 1'b0);
    offer(KIND_WRITE, 16'hFFFF, 1'b0);
    offer(KIND_READ, 16'h0000, 1'b1);
    offer(KIND_SPARE_FIRST, 16'h5555, 1'b1);
    offer(KIND_SPARE_MID, 16'h0000, 1'b0);
    offer(KIND_SPARE_LAST, 16'hAAAA, 1'b1);
    offer(KIND_ALLOC, 16'h0000, 1'b0);

    // Tiny map: range errors, count saturation, full map with a nonzero count.
    drain();
    configure(4, 0);
    offer(KIND_FORMAT, 16'h0000, 1'b0);
    offer(KIND_FREE, 16'h0004, 1'b0);
    offer(KIND_READ, 16'hFFFF, 1'b0);
    offer(KIND_FREE, 16'h0000, 1'b0);
    for (int b = 0; b < 4; b++) offer(KIND_WRITE, BN_W'(b), 1'b1);
    offer(KIND_ALLOC, 16'h0000, 1'b0);
    offer(KIND_FREE, 16'h0002, 1'b0);
    offer(KIND_ALLOC, 16'h0000, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          total = 1;
          reserved = 0;
        end
        1: begin
          total = 17'h1FFFF;
          reserved = 65536;
        end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 7) total = $urandom_range(1, 96);
          else if (pick < 9) total = $urandom_range(97, 4096);
          else total = $urandom_range(4097, 65536);
          pick = $urandom_range(0, 9);
          if (pick == 0) reserved = 65536;
          else if (pick < 3) reserved = 0;
          else reserved = $urandom_range(0, (total < 48) ? total + 2 : 48);
        end
      endcase
      configure(total, reserved);
      steady = (p == 5);
      // block the reply side while requests keep coming
      if (p == 2) hold_wanted = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE) @(negedge clk_i);
    $display("Covered %0d requests and %0d replies, %0d formats, over %0d register settings,",
             shadow.requests_seen, shadow.replies_seen, shadow.formats_seen, PHASES + 2);
    $display("including a held reply channel and a stretch with no idle cycles.");
    if (shadow.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
